// ===== design/tcposf_pkg.sv =====
// shared types and constants for the tcp option subtype finder
`timescale 1ns / 1ps

package tcposf_pkg;

    // fixed field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SUBTYPE_W = 4;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned STATUS_W  = 2;
    // option start plus a full length byte
    localparam int unsigned END_W     = 9;

    // reset value of the searched kind
    localparam logic [BYTE_W-1:0] OPTION_KIND_RESET = 8'd30;

    // option kinds with fixed meaning
    localparam logic [BYTE_W-1:0] KIND_END_OF_LIST = 8'd0;
    localparam logic [BYTE_W-1:0] KIND_NO_OP       = 8'd1;

    // smallest legal length byte
    localparam logic [BYTE_W-1:0] MIN_OPTION_LEN = 8'd2;

    // parse status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT_LEN = 2'd1,
        STATUS_PAST_END  = 2'd2
    } parse_status_t;

    // one request on the input channel
    typedef struct packed {
        logic [BYTE_W-1:0]    option_byte;
        logic                 last_byte;
        logic [SUBTYPE_W-1:0] wanted_subtype;
    } opt_in_t;

    // one result on the output channel
    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    match_offset;
        logic [STATUS_W-1:0] parse_status;
    } opt_out_t;

endpackage

// ===== design/tcposf_in_reg.sv =====
// input register stage holding one option byte request
`timescale 1ns / 1ps

module tcposf_in_reg
    import tcposf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  opt_in_t s_data,
    output logic    q_valid,
    input  logic    q_ready,
    output opt_in_t q_data
);

    logic    valid_reg;
    logic    valid_next;
    opt_in_t data_reg;

    // take a new request whenever the held one is empty or moving on
    assign s_ready = !valid_reg || q_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ===== design/tcposf_walker.sv =====
// option list walker holding the header state of one tcp header
`timescale 1ns / 1ps

module tcposf_walker
    import tcposf_pkg::*;
#(
    parameter int unsigned MAX_OPTION_BYTES = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] option_kind,
    input  logic              step,
    input  opt_in_t           in_data,
    output opt_out_t          result
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_OPTION_BYTES);
    localparam logic [END_W-1:0] MAX_END = END_W'(MAX_OPTION_BYTES);

    // header state
    logic [POS_W-1:0]     byte_position_reg, byte_position_next;
    logic [POS_W-1:0]     next_start_reg, next_start_next;
    logic [POS_W-1:0]     cur_start_reg, cur_start_next;
    logic [BYTE_W-1:0]    cur_kind_reg, cur_kind_next;
    logic                 search_done_reg, search_done_next;
    logic                 match_seen_reg, match_seen_next;
    logic [POS_W-1:0]     match_pos_reg, match_pos_next;
    logic [STATUS_W-1:0]  error_code_reg, error_code_next;
    logic [SUBTYPE_W-1:0] held_subtype_reg, held_subtype_next;

    logic [SUBTYPE_W-1:0] subtype;
    logic [BYTE_W-1:0]    b;
    logic [POS_W:0]       len_pos;
    logic [POS_W:0]       sub_pos;
    logic [END_W-1:0]     opt_end;
    logic [STATUS_W-1:0]  status;

    assign b       = in_data.option_byte;
    assign subtype = (byte_position_reg == '0) ? in_data.wanted_subtype : held_subtype_reg;
    assign len_pos = {1'b0, cur_start_reg} + (POS_W+1)'(1);
    assign sub_pos = {1'b0, cur_start_reg} + (POS_W+1)'(2);
    assign opt_end = END_W'(cur_start_reg) + END_W'(b);

    // walk one byte of the kind-length-value list
    always_comb begin
        byte_position_next = byte_position_reg;
        next_start_next    = next_start_reg;
        cur_start_next     = cur_start_reg;
        cur_kind_next      = cur_kind_reg;
        search_done_next   = search_done_reg;
        match_seen_next    = match_seen_reg;
        match_pos_next     = match_pos_reg;
        error_code_next    = error_code_reg;
        held_subtype_next  = subtype;

        if (byte_position_reg < MAX_POS) begin
            byte_position_next = byte_position_reg + POS_W'(1);
            if (!search_done_reg) begin
                if (byte_position_reg == next_start_reg) begin
                    // kind byte
                    cur_start_next = byte_position_reg;
                    cur_kind_next  = b;
                    if (b == KIND_END_OF_LIST) begin
                        search_done_next = 1'b1;
                    end else if (b == KIND_NO_OP && b != option_kind) begin
                        next_start_next = byte_position_reg + POS_W'(1);
                    end else begin
                        next_start_next = byte_position_reg + POS_W'(2);
                    end
                end else if ({1'b0, byte_position_reg} == len_pos) begin
                    // length byte
                    if (b < MIN_OPTION_LEN) begin
                        error_code_next  = STATUS_SHORT_LEN;
                        search_done_next = 1'b1;
                    end else if (opt_end > MAX_END) begin
                        error_code_next  = STATUS_PAST_END;
                        search_done_next = 1'b1;
                    end else begin
                        next_start_next = opt_end[POS_W-1:0];
                    end
                end else if ({1'b0, byte_position_reg} == sub_pos
                             && cur_kind_reg == option_kind) begin
                    // subtype byte of a searched-kind option
                    if (b[BYTE_W-1 -: SUBTYPE_W] == subtype) begin
                        match_seen_next  = 1'b1;
                        match_pos_next   = cur_start_reg;
                        search_done_next = 1'b1;
                    end
                end
            end
        end
    end

    // summary of the header on its last byte
    always_comb begin
        status = error_code_next;
        if (!search_done_next && next_start_next > byte_position_next) begin
            status = STATUS_PAST_END;
        end
        result.found        = match_seen_next;
        result.match_offset = match_seen_next ? match_pos_next : '0;
        result.parse_status = status;
    end

    // state update, cleared after each header
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && in_data.last_byte)) begin
            byte_position_reg <= '0;
            next_start_reg    <= '0;
            cur_start_reg     <= '0;
            cur_kind_reg      <= '0;
            search_done_reg   <= 1'b0;
            match_seen_reg    <= 1'b0;
            match_pos_reg     <= '0;
            error_code_reg    <= STATUS_OK;
            held_subtype_reg  <= '0;
        end else if (step) begin
            byte_position_reg <= byte_position_next;
            next_start_reg    <= next_start_next;
            cur_start_reg     <= cur_start_next;
            cur_kind_reg      <= cur_kind_next;
            search_done_reg   <= search_done_next;
            match_seen_reg    <= match_seen_next;
            match_pos_reg     <= match_pos_next;
            error_code_reg    <= error_code_next;
            held_subtype_reg  <= held_subtype_next;
        end
    end

endmodule

// ===== design/tcposf_core.sv =====
// result register around the option list walker
`timescale 1ns / 1ps

module tcposf_core
    import tcposf_pkg::*;
#(
    parameter int unsigned MAX_OPTION_BYTES = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] option_kind,
    input  logic              in_valid,
    output logic              in_ready,
    input  opt_in_t           in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output opt_out_t          m_data
);

    // result register
    logic     out_valid_reg, out_valid_next;
    opt_out_t out_data_reg;
    opt_out_t result;

    logic     fire;

    // a last byte needs room in the result register, other bytes never wait
    assign in_ready = !in_data.last_byte || !out_valid_reg || m_ready;
    assign fire     = in_valid && in_ready;

    // list walker with the header state
    tcposf_walker #(
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .option_kind (option_kind),
        .step        (fire),
        .in_data     (in_data),
        .result      (result)
    );

    // result valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire && in_data.last_byte) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_data.last_byte) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/tcp_option_subtype_finder_top.sv =====
// top level of the tcp option subtype finder
`timescale 1ns / 1ps

// Finds the first option of the configured kind whose subtype nibble
// matches the wanted subtype in the options area of a TCP header.
// Input channel (s_valid/s_ready/s_data): one option byte per request,
// last_byte marks the end of a header, wanted_subtype is taken from the
// first byte of each header. Output channel (m_valid/m_ready/m_data): one
// result per header, issued for its last byte, with found, the offset of
// the matching kind byte and a parse status.
// cfg_wr_en/cfg_wr_data write the searched option kind (reset 30); write
// it only between headers while no result is pending.
// Throughput is one byte per cycle: each byte passes the input register
// and one compare-and-add step in the walker; a last byte's result goes into the result register.
// The last byte passes the input register, then the result register drives m_valid.
// When the receiver stalls, bytes other than last bytes keep flowing; a
// last byte waits in the input register until the result register frees.
// Reset (aresetn low, synchronous) empties both registers, clears the
// header state and restores the option kind.

module tcp_option_subtype_finder_top
    import tcposf_pkg::*;
#(
    parameter int unsigned MAX_OPTION_BYTES = 40
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  opt_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output opt_out_t          m_data
);

    logic [BYTE_W-1:0] option_kind_reg;
    logic              q_valid;
    logic              q_ready;
    opt_in_t           q_data;

    // searched kind register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            option_kind_reg <= OPTION_KIND_RESET;
        end else if (cfg_wr_en) begin
            option_kind_reg <= cfg_wr_data;
        end
    end

    // input register
    tcposf_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    // list walker and result register
    tcposf_core #(
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .option_kind (option_kind_reg),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_data     (q_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the tcp option subtype finder
`timescale 1ns / 1ps

module tb_top;
    import tcposf_pkg::*;

    localparam int unsigned MAX_OPT     = 40;
    localparam int unsigned STALL_LIMIT = 20000;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    opt_in_t           s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    opt_out_t          m_data;

    // searched kind as the block should hold it
    logic [BYTE_W-1:0] kind_reg = OPTION_KIND_RESET;

    // header walk state of the predictor
    logic [POS_W-1:0]     hs_pos;
    logic [POS_W-1:0]     hs_next_start;
    logic [POS_W-1:0]     hs_cur_start;
    logic [BYTE_W-1:0]    hs_cur_kind;
    logic                 hs_done;
    logic                 hs_match;
    logic [POS_W-1:0]     hs_match_pos;
    parse_status_t        hs_status;
    logic [SUBTYPE_W-1:0] hs_subtype;

    opt_out_t    pending_results[$];
    int unsigned mismatch_count = 0;
    bit          idle_en        = 1'b1;
    int unsigned hold_request   = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    tcp_option_subtype_finder_top #(
        .MAX_OPTION_BYTES(MAX_OPT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always #1 aclk = ~aclk;

    // predictor: start of a fresh header
    function automatic void clear_walk();
        hs_pos        = '0;
        hs_next_start = '0;
        hs_cur_start  = '0;
        hs_cur_kind   = '0;
        hs_done       = 1'b0;
        hs_match      = 1'b0;
        hs_match_pos  = '0;
        hs_status     = STATUS_OK;
        hs_subtype    = '0;
    endfunction

    // predictor: one option byte, returns 1 when it closes a header
    function automatic bit walk_option_byte(input opt_in_t req, output opt_out_t res);
        logic [POS_W-1:0]  pos;
        logic [END_W-1:0]  opt_end;
        logic [BYTE_W-1:0] b;
        b   = req.option_byte;
        pos = hs_pos;
        res = '0;
        if (pos == 0) begin
            hs_subtype = req.wanted_subtype;
        end
        if (pos < MAX_OPT) begin
            if (!hs_done) begin
                if (pos == hs_next_start) begin
                    // kind byte of a new option
                    hs_cur_start = pos;
                    hs_cur_kind  = b;
                    if (b == KIND_END_OF_LIST) begin
                        hs_done = 1'b1;
                    end else if (b == KIND_NO_OP && b != kind_reg) begin
                        hs_next_start = POS_W'(pos + 1);
                    end else begin
                        hs_next_start = POS_W'(pos + 2);
                    end
                end else if (pos == hs_cur_start + 1) begin
                    // length byte
                    opt_end = hs_cur_start + b;
                    if (b < MIN_OPTION_LEN) begin
                        hs_status = STATUS_SHORT_LEN;
                        hs_done   = 1'b1;
                    end else if (opt_end > MAX_OPT) begin
                        hs_status = STATUS_PAST_END;
                        hs_done   = 1'b1;
                    end else begin
                        hs_next_start = opt_end[POS_W-1:0];
                    end
                end else if (pos == hs_cur_start + 2 && hs_cur_kind == kind_reg) begin
                    // subtype byte of a searched option
                    if (b[7:4] == hs_subtype) begin
                        hs_match     = 1'b1;
                        hs_match_pos = hs_cur_start;
                        hs_done      = 1'b1;
                    end
                end
            end
            hs_pos = POS_W'(pos + 1);
        end
        if (!req.last_byte) begin
            return 1'b0;
        end
        res.found        = hs_match;
        res.match_offset = hs_match ? hs_match_pos : '0;
        res.parse_status = (!hs_done && hs_next_start > hs_pos) ? STATUS_PAST_END : hs_status;
        clear_walk();
        return 1'b1;
    endfunction

    // send one request, predict on acceptance
    task automatic send_req(input opt_in_t req);
        opt_out_t res;
        while (idle_en && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (walk_option_byte(req, res)) begin
            pending_results.push_back(res);
        end
    endtask

    // one header, wanted subtype on its first byte
    task automatic send_header(input byte_q_t hdr, input logic [SUBTYPE_W-1:0] wanted);
        opt_in_t req;
        for (int i = 0; i < hdr.size(); i++) begin
            req.option_byte = hdr[i];
            req.last_byte   = (i == hdr.size() - 1);
            if (i == 0) begin
                req.wanted_subtype = wanted;
            end else begin
                req.wanted_subtype = SUBTYPE_W'($urandom_range(15));
            end
            send_req(req);
        end
    endtask

    // random header: mostly well formed, some noise, some broken
    task automatic send_random_header(output int unsigned n_sent);
        byte_q_t              hdr;
        logic [SUBTYPE_W-1:0] wanted;
        logic [3:0]           hi;
        logic [3:0]           lo;
        int unsigned          mode;
        int unsigned          target;
        int unsigned          room;
        int unsigned          len;
        int unsigned          sel;
        int unsigned          cut;
        wanted = SUBTYPE_W'($urandom_range(15));
        mode   = $urandom_range(99);
        if (mode < 15) begin
            // noise, now and then running past the options area
            target = ($urandom_range(99) < 25) ? $urandom_range(41, 50) : $urandom_range(1, 40);
            repeat (target) begin
                if ($urandom_range(3) == 0) begin
                    hdr.push_back(kind_reg);
                end else begin
                    hdr.push_back(BYTE_W'($urandom_range(255)));
                end
            end
        end else begin
            target = $urandom_range(1, MAX_OPT);
            while (hdr.size() < target) begin
                room = target - hdr.size();
                sel  = $urandom_range(99);
                if (sel < 20 || room < 2) begin
                    hdr.push_back(KIND_NO_OP);
                end else if (sel < 25) begin
                    // end of list then padding
                    hdr.push_back(KIND_END_OF_LIST);
                    while (hdr.size() < target) begin
                        hdr.push_back($urandom_range(1) ? 8'h00 : BYTE_W'($urandom_range(255)));
                    end
                end else if (sel < 65 && room >= 3) begin
                    // searched option, subtype right about half the time
                    len = $urandom_range(3, (room < 12) ? room : 12);
                    hi  = $urandom_range(1) ? wanted : SUBTYPE_W'($urandom_range(15));
                    lo  = SUBTYPE_W'($urandom_range(15));
                    hdr.push_back(kind_reg);
                    hdr.push_back(BYTE_W'(len));
                    hdr.push_back({hi, lo});
                    repeat (len - 3) hdr.push_back(BYTE_W'($urandom_range(255)));
                end else begin
                    // some other option
                    len = $urandom_range(2, (room < 10) ? room : 10);
                    hdr.push_back(BYTE_W'($urandom_range(2, 255)));
                    hdr.push_back(BYTE_W'(len));
                    repeat (len - 2) hdr.push_back(BYTE_W'($urandom_range(255)));
                end
            end
            if (mode >= 85) begin
                if ($urandom_range(1)) begin
                    // cut short inside an option
                    cut = $urandom_range(1, hdr.size());
                    while (hdr.size() > cut) void'(hdr.pop_back());
                end else begin
                    // bad length on a trailing option
                    while (hdr.size() > 37) void'(hdr.pop_back());
                    hdr.push_back($urandom_range(1) ? kind_reg : BYTE_W'($urandom_range(2, 255)));
                    sel = $urandom_range(2);
                    if (sel == 0) begin
                        hdr.push_back(8'd0);
                    end else if (sel == 1) begin
                        hdr.push_back(8'd1);
                    end else begin
                        hdr.push_back(BYTE_W'($urandom_range(41, 255)));
                    end
                    if ($urandom_range(1)) hdr.push_back(BYTE_W'($urandom_range(255)));
                end
            end
        end
        send_header(hdr, wanted);
        n_sent = hdr.size();
    endtask

    task automatic send_random_traffic(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < n_bytes) begin
            send_random_header(n);
            sent += n;
        end
    endtask

    // drop valid and wait for every pending result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // write the searched kind while the block is idle
    task automatic write_option_kind(input logic [BYTE_W-1:0] value);
        drain_results();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        kind_reg = value;
    endtask

    // hand-built headers for the corner cases
    task automatic test_directed();
        byte_q_t hdr;
        // extreme byte values, match behind another option
        hdr = '{8'hFF, 8'd2, kind_reg, 8'd4, 8'hF0, 8'h00};
        send_header(hdr, 4'd15);
        // no-ops, searched kind of length two, match whose body runs past the end
        hdr = '{KIND_NO_OP, KIND_NO_OP, kind_reg, 8'd2, kind_reg, 8'd8, 8'h0F};
        send_header(hdr, 4'd0);
        // end of list alone
        hdr = '{KIND_END_OF_LIST};
        send_header(hdr, 4'd7);
        // length one and length zero
        hdr = '{8'd5, 8'd1};
        send_header(hdr, 4'd3);
        hdr = '{8'd5, 8'd0};
        send_header(hdr, 4'd3);
        // option past the bound
        hdr = '{8'd8, 8'hFF};
        send_header(hdr, 4'd9);
        // wrong subtype, cut off in the body
        hdr = '{kind_reg, 8'd6, 8'h30};
        send_header(hdr, 4'd4);
        // cut off before the length byte
        hdr = '{kind_reg};
        send_header(hdr, 4'd0);
    endtask

    // random traffic under several searched kinds
    task automatic test_kind_sweep();
        logic [BYTE_W-1:0] kinds[6];
        kinds[0] = OPTION_KIND_RESET;
        kinds[1] = KIND_END_OF_LIST;
        kinds[2] = KIND_NO_OP;
        kinds[3] = 8'hFF;
        kinds[4] = BYTE_W'($urandom_range(255));
        kinds[5] = BYTE_W'($urandom_range(2, 254));
        foreach (kinds[k]) begin
            write_option_kind(kinds[k]);
            send_random_traffic(200);
        end
    endtask

    // back to back on both sides
    task automatic test_no_idle_stretch();
        write_option_kind(OPTION_KIND_RESET);
        idle_en = 1'b0;
        send_random_traffic(200);
        drain_results();
        idle_en = 1'b1;
    endtask

    // receiver holds off while requests keep coming
    task automatic test_receiver_hold_off();
        hold_request = 300;
        send_random_traffic(120);
    endtask

    // sender stops until all results are back, then carries on
    task automatic test_sender_pause();
        drain_results();
        repeat ($urandom_range(1, 20)) @(posedge aclk);
        send_random_traffic(80);
    endtask

    // receiver ready with random stalls and requested hold-offs
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready  <= 1'b0;
        end else if (idle_en && $urandom_range(99) < 27) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: found=%0d offset=%0d status=%0d",
                             m_data.found, m_data.match_offset, m_data.parse_status);
                end
            end else begin
                if (m_data.found !== pending_results[0].found ||
                    m_data.match_offset !== pending_results[0].match_offset ||
                    m_data.parse_status !== pending_results[0].parse_status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        // fields in order found, offset, status
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 pending_results[0].found, pending_results[0].match_offset,
                                 pending_results[0].parse_status, m_data.found,
                                 m_data.match_offset, m_data.parse_status);
                    end
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tcp_option_subtype_finder_top verification failed");
            $finish;
        end
    end

    initial begin
        clear_walk();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_kind_sweep();
        test_no_idle_stretch();
        test_receiver_hold_off();
        test_sender_pause();
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tcp_option_subtype_finder_top verification clean");
        end else begin
            $display("tcp_option_subtype_finder_top verification failed");
        end
        $finish;
    end

endmodule
